@@ design/fdt_pkg.sv @@
// ----------------------------------------------------------------------------
// fdt_pkg: shared types, constants and helpers
// Word formats, register indexes and reset values, lane control and the
// saturation helpers of the stereo feedback delay with tone filter.
// ----------------------------------------------------------------------------
package fdt_pkg;

  // Sizes of the delay memory and sample formats
  localparam int unsigned DELAY_DEPTH_DEF = 32768;
  localparam int unsigned MIN_DELAY       = 4;
  localparam int SAMPLE_W = 24;   // Q1.23
  localparam int STATE_W  = 32;   // Q1.31 filter state
  localparam int DIST_W   = 16;   // tap distance register

  // Register widths
  localparam int GAIN_W  = 17;    // unsigned Q1.16
  localparam int FB_W    = 15;
  localparam int COEFF_W = 16;
  localparam int MIX_W   = 18;    // signed Q2.16

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_MIX   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_MIX    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DELAY    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DELAY   = 8'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0]        RST_WET_GAIN      = 17'd21627;
  localparam logic [GAIN_W-1:0]        RST_DRY_GAIN      = 17'd58399;
  localparam logic [FB_W-1:0]          RST_FEEDBACK_GAIN = 15'd22708;
  localparam logic [COEFF_W-1:0]       RST_FILTER_COEFF  = 16'd62000;
  localparam logic signed [MIX_W-1:0]  RST_LOWPASS_MIX   = 18'sd0;
  localparam logic [GAIN_W-1:0]        RST_DIRECT_MIX    = 17'd65536;
  localparam logic [DIST_W-1:0]        RST_LEFT_DELAY    = 16'd12000;
  localparam logic [DIST_W-1:0]        RST_RIGHT_DELAY   = 16'd3240;

  // Serial multiplier: coefficient bits taken one per cycle, two's complement
  localparam int MUL_W   = 18;
  localparam int MCAND_W = 33;
  localparam int PROD_W  = MCAND_W + 1 + MUL_W;
  localparam int SUM_W   = PROD_W + 1;

  // Rounding constants and saturation bounds on the sum width
  localparam logic signed [SUM_W-1:0] HALF_Q16 = SUM_W'(longint'(1) <<< 15);
  localparam logic signed [SUM_W-1:0] HALF_Q24 = SUM_W'(longint'(1) <<< 23);
  localparam logic signed [SUM_W-1:0] SMP_HI =
    SUM_W'((longint'(1) <<< (SAMPLE_W - 1)) - longint'(1));
  localparam logic signed [SUM_W-1:0] SMP_LO = -SMP_HI - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ST_HI =
    SUM_W'((longint'(1) <<< (STATE_W - 1)) - longint'(1));
  localparam logic signed [SUM_W-1:0] ST_LO = -ST_HI - SUM_W'(1);

  // Control group of one multiplier lane
  typedef struct packed {
    logic load;   // take operands, clear accumulator
    logic step;   // consume one coefficient bit
    logic last;   // sign bit of the coefficient: subtract
  } lane_ctrl_t;

  // Saturate to a Q1.23 sample
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SMP_HI) begin
      r = SMP_HI[SAMPLE_W-1:0];
    end else if (v < SMP_LO) begin
      r = SMP_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Saturate to the 32-bit filter state
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [SUM_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > ST_HI) begin
      r = ST_HI[STATE_W-1:0];
    end else if (v < ST_LO) begin
      r = ST_LO[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/fdt_ram.sv @@
// ----------------------------------------------------------------------------
// fdt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fdt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/fdt_tap_addr.sv @@
// ----------------------------------------------------------------------------
// fdt_tap_addr: tap address from write position and distance
// Clamps the distance to the legal span and wraps the sum into the memory.
// ----------------------------------------------------------------------------
module fdt_tap_addr import fdt_pkg::*; #(
  parameter int unsigned DEPTH = DELAY_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = ($clog2(DEPTH + 1) > DIST_W) ? $clog2(DEPTH + 1) : DIST_W
) (
  input  logic [AW-1:0]     pos_i,
  input  logic [DIST_W-1:0] dist_i,
  output logic [AW-1:0]     idx_o
);

  logic [CW-1:0] dist_ext;
  logic [CW-1:0] dist_clamped;
  logic [CW:0]   sum;
  logic [CW:0]   wrapped;

  // clamp to the minimum delay below and the memory depth above
  always_comb begin
    dist_ext = CW'(dist_i);
    priority if (dist_ext < CW'(MIN_DELAY)) begin
      dist_clamped = CW'(MIN_DELAY);
    end else if (dist_ext > CW'(DEPTH)) begin
      dist_clamped = CW'(DEPTH);
    end else begin
      dist_clamped = dist_ext;
    end
  end

  // sum stays below twice the depth: one compare and subtract wraps it
  always_comb begin
    sum = (CW+1)'(pos_i) + (CW+1)'(dist_clamped);
    if (sum >= (CW+1)'(DEPTH)) begin
      wrapped = sum - (CW+1)'(DEPTH);
    end else begin
      wrapped = sum;
    end
  end

  assign idx_o = wrapped[AW-1:0];

endmodule

@@ design/fdt_mac_lane.sv @@
// ----------------------------------------------------------------------------
// fdt_mac_lane: bit-serial multiplier lane
// Serial-parallel multiply: one coefficient bit per cycle while step is set, LSB first, the
// partial sum shifting right into a low-bit shift register.
// ----------------------------------------------------------------------------
module fdt_mac_lane import fdt_pkg::*; (
  input  logic                      clk_i,
  input  lane_ctrl_t                ctrl_i,
  input  logic signed [MCAND_W-1:0] mcand_i,
  input  logic [MUL_W-1:0]          coef_i,   // two's complement
  output logic signed [PROD_W-1:0]  prod_o
);

  localparam int XE_W = MCAND_W + 2;

  logic signed [MCAND_W-1:0] x_q;
  logic [MUL_W-1:0]          m_q;
  logic signed [MCAND_W:0]   h_q;
  logic [MUL_W-1:0]          l_q;
  logic signed [XE_W-1:0]    x_ext;
  logic signed [XE_W-1:0]    addend;
  logic signed [XE_W-1:0]    psum;

  // add, or subtract on the sign bit, the multiplicand
  always_comb begin
    x_ext  = XE_W'(x_q);
    addend = '0;
    if (m_q[0]) begin
      addend = ctrl_i.last ? -x_ext : x_ext;
    end
    psum = XE_W'(h_q) + addend;
  end

  // shift the partial sum right, low bit into the product shift register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= mcand_i;
      m_q <= coef_i;
      h_q <= '0;
      l_q <= '0;
    end else if (ctrl_i.step) begin
      h_q <= psum[XE_W-1:1];
      l_q <= {psum[0], l_q[MUL_W-1:1]};
      m_q <= {1'b0, m_q[MUL_W-1:1]};
    end
  end

  assign prod_o = {h_q, l_q};

endmodule

@@ design/stereo_feedback_delay_tone.sv @@
// Each stereo word takes three passes (load, one step per coefficient bit, sum,
// round) through the bit-serial multiplier lanes; no new word is taken until
// the last one has reached the output register.
// Reset: rst_ni clears the control and configuration registers at once, then a
// clearing pass zeroes the delay memory, one entry a cycle, with no input taken.
// Configuration writes are taken at any time, also during the clearing pass.
// ----------------------------------------------------------------------------
// stereo_feedback_delay_tone: stereo feedback delay with tone filter
// Shared mono delay memory, two taps, one-pole lowpass in the feedback path,
// all products formed by three bit-serial multiplier lanes.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_tone import fdt_pkg::*; #(
  parameter int unsigned DELAY_DEPTH = DELAY_DEPTH_DEF,
  localparam int AW = $clog2(DELAY_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*SAMPLE_W-1:0] s_axis_tdata,   // left_in [23:0], right_in [47:24]
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*SAMPLE_W-1:0] m_axis_tdata,   // left_out [23:0], right_out [47:24]
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RDL   = 4'd2;
  localparam logic [3:0] ST_RDR   = 4'd3;
  localparam logic [3:0] ST_TAPS  = 4'd4;
  localparam logic [3:0] ST_LOAD  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_RND   = 4'd8;
  localparam logic [3:0] ST_WR    = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  // multiply passes
  localparam logic [1:0] PH_MIX   = 2'd0;   // input and feedback sum, left out
  localparam logic [1:0] PH_FILT  = 2'd1;   // lowpass, right out
  localparam logic [1:0] PH_STORE = 2'd2;   // word written back

  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);
  localparam logic [AW-1:0]    ADDR_TOP = AW'(DELAY_DEPTH - 1);

  // control state
  logic [3:0]       fsm_q, fsm_d;
  logic [1:0]       phase_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    clr_q;
  logic [AW-1:0]    wp_q;
  logic             out_valid_q;

  // configuration registers
  logic [GAIN_W-1:0]       wet_q, dry_q, direct_q;
  logic [FB_W-1:0]         fb_q;
  logic [COEFF_W-1:0]      coeff_q;
  logic signed [MIX_W-1:0] lmix_q;
  logic [DIST_W-1:0]       ldist_q, rdist_q;

  // filter state
  logic signed [STATE_W-1:0] filt_q;

  // working words
  logic signed [SAMPLE_W-1:0] a_q, b_q, dl_q, dr_q, tmp_q, word_q;
  logic signed [SAMPLE_W-1:0] lo_q, ro_q, out_lo_q, out_ro_q;
  logic signed [SUM_W-1:0]    sum_a_q, sum_b_q;

  // datapath nets
  logic                        in_acc, out_load;
  logic [AW-1:0]               li, ri;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0]         ram_wdata, ram_rdata;
  logic signed [STATE_W-1:0]   t31;
  logic signed [SAMPLE_W:0]    ab_sum, tap_sum;
  lane_ctrl_t                  lane_ctrl;
  logic signed [MCAND_W-1:0]   mc0, mc1, mc2;
  logic [MUL_W-1:0]            cf0, cf1, cf2;
  logic signed [PROD_W-1:0]    p0, p1, p2;
  logic signed [SUM_W-1:0]     sum_a_d, sum_b_d;
  logic signed [SUM_W-1:0]     rnd_a, rnd_b, res_a, res_b;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (fsm_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (fsm_q == ST_FIN) & (~out_valid_q | m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ro_q, out_lo_q};
  assign t31           = {tmp_q, 8'h00};

  // tap addresses
  fdt_tap_addr #(.DEPTH(DELAY_DEPTH)) u_tap_l (
    .pos_i  (wp_q),
    .dist_i (ldist_q),
    .idx_o  (li)
  );

  fdt_tap_addr #(.DEPTH(DELAY_DEPTH)) u_tap_r (
    .pos_i  (wp_q),
    .dist_i (rdist_q),
    .idx_o  (ri)
  );

  // delay memory: clearing pass writes zero, then one word per item
  assign ram_we    = (fsm_q == ST_CLEAR) | (fsm_q == ST_WR);
  assign ram_waddr = (fsm_q == ST_CLEAR) ? clr_q : wp_q;
  assign ram_wdata = (fsm_q == ST_CLEAR) ? '0 : word_q;
  assign ram_raddr = (fsm_q == ST_RDL) ? li : ri;

  fdt_ram #(.WIDTH(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // lane operands for each pass
  always_comb begin
    ab_sum  = (SAMPLE_W+1)'(a_q) + (SAMPLE_W+1)'(b_q);
    tap_sum = (SAMPLE_W+1)'(dl_q) + (SAMPLE_W+1)'(dr_q);
    mc0 = '0;
    mc1 = '0;
    mc2 = '0;
    cf0 = '0;
    cf1 = '0;
    cf2 = '0;
    unique case (phase_q)
      PH_MIX: begin
        mc0 = MCAND_W'(ab_sum);
        cf0 = MUL_W'(wet_q);
        mc1 = MCAND_W'(tap_sum);
        cf1 = MUL_W'(fb_q);
        mc2 = MCAND_W'(a_q);
        cf2 = MUL_W'(dry_q);
      end
      PH_FILT: begin
        mc0 = MCAND_W'(filt_q) - MCAND_W'(t31);
        cf0 = MUL_W'(coeff_q);
        mc2 = MCAND_W'(b_q);
        cf2 = MUL_W'(dry_q);
      end
      PH_STORE: begin
        mc0 = MCAND_W'(filt_q);
        cf0 = lmix_q;
        mc1 = MCAND_W'(t31);
        cf1 = MUL_W'(direct_q);
      end
      default: begin
      end
    endcase
  end

  assign lane_ctrl.load = (fsm_q == ST_LOAD);
  assign lane_ctrl.step = (fsm_q == ST_MUL);
  assign lane_ctrl.last = (cnt_q == CNT_LAST);

  fdt_mac_lane u_lane0 (.clk_i(clk_i), .ctrl_i(lane_ctrl), .mcand_i(mc0), .coef_i(cf0),
                        .prod_o(p0));
  fdt_mac_lane u_lane1 (.clk_i(clk_i), .ctrl_i(lane_ctrl), .mcand_i(mc1), .coef_i(cf1),
                        .prod_o(p1));
  fdt_mac_lane u_lane2 (.clk_i(clk_i), .ctrl_i(lane_ctrl), .mcand_i(mc2), .coef_i(cf2),
                        .prod_o(p2));

  // pass sums: the Q1.23 terms are lifted to the product scale
  always_comb begin
    if (phase_q == PH_FILT) begin
      sum_a_d = SUM_W'(p0) + (SUM_W'(t31) <<< 16);
      sum_b_d = SUM_W'(p2) + (SUM_W'(dr_q) <<< 16);
    end else begin
      sum_a_d = SUM_W'(p0) + SUM_W'(p1);
      sum_b_d = SUM_W'(p2) + (SUM_W'(dl_q) <<< 16);
    end
  end

  // round half up, then floor shift
  always_comb begin
    if (phase_q == PH_STORE) begin
      rnd_a = sum_a_q + HALF_Q24;
      res_a = rnd_a >>> 24;
    end else begin
      rnd_a = sum_a_q + HALF_Q16;
      res_a = rnd_a >>> 16;
    end
    rnd_b = sum_b_q + HALF_Q16;
    res_b = rnd_b >>> 16;
  end

  // sequencer
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      ST_CLEAR: if (clr_q == ADDR_TOP) fsm_d = ST_IDLE;
      ST_IDLE:  if (in_acc) fsm_d = ST_RDL;
      ST_RDL:   fsm_d = ST_RDR;
      ST_RDR:   fsm_d = ST_TAPS;
      ST_TAPS:  fsm_d = ST_LOAD;
      ST_LOAD:  fsm_d = ST_MUL;
      ST_MUL:   if (cnt_q == CNT_LAST) fsm_d = ST_SUM;
      ST_SUM:   fsm_d = ST_RND;
      ST_RND:   fsm_d = (phase_q == PH_STORE) ? ST_WR : ST_LOAD;
      ST_WR:    fsm_d = ST_FIN;
      ST_FIN:   if (out_load) fsm_d = ST_IDLE;
      default:  fsm_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_CLEAR;
      phase_q     <= PH_MIX;
      cnt_q       <= '0;
      clr_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      filt_q      <= '0;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (fsm_q == ST_LOAD) begin
        cnt_q <= '0;
      end else if (fsm_q == ST_MUL) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (fsm_q == ST_IDLE) begin
        phase_q <= PH_MIX;
      end else if (fsm_q == ST_RND) begin
        // back to the first pass once the store pass has rounded
        phase_q <= (phase_q == PH_STORE) ? PH_MIX : phase_q + 1'b1;
      end
      if ((fsm_q == ST_RND) && (phase_q == PH_FILT)) begin
        filt_q <= sat_state(res_a);
      end
      if (fsm_q == ST_WR) begin
        wp_q <= (wp_q == '0) ? ADDR_TOP : wp_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q    <= RST_WET_GAIN;
      dry_q    <= RST_DRY_GAIN;
      fb_q     <= RST_FEEDBACK_GAIN;
      coeff_q  <= RST_FILTER_COEFF;
      lmix_q   <= RST_LOWPASS_MIX;
      direct_q <= RST_DIRECT_MIX;
      ldist_q  <= RST_LEFT_DELAY;
      rdist_q  <= RST_RIGHT_DELAY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WET_GAIN:      wet_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DRY_GAIN:      dry_q    <= cfg_data_i[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: fb_q     <= cfg_data_i[FB_W-1:0];
        REG_FILTER_COEFF:  coeff_q  <= cfg_data_i[COEFF_W-1:0];
        REG_LOWPASS_MIX:   lmix_q   <= cfg_data_i[MIX_W-1:0];
        REG_DIRECT_MIX:    direct_q <= cfg_data_i[GAIN_W-1:0];
        REG_LEFT_DELAY:    ldist_q  <= cfg_data_i[DIST_W-1:0];
        REG_RIGHT_DELAY:   rdist_q  <= cfg_data_i[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= s_axis_tdata[SAMPLE_W-1:0];
      b_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
    // taps arrive from the registered read in the cycle after their address
    if (fsm_q == ST_RDR) begin
      dl_q <= ram_rdata;
    end
    if (fsm_q == ST_TAPS) begin
      dr_q <= ram_rdata;
    end
    if (fsm_q == ST_SUM) begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
    if (fsm_q == ST_RND) begin
      unique case (phase_q)
        PH_MIX: begin
          tmp_q <= sat_sample(res_a);
          lo_q  <= sat_sample(res_b);
        end
        PH_FILT: begin
          ro_q <= sat_sample(res_b);
        end
        PH_STORE: begin
          word_q <= sat_sample(res_a);
        end
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_lo_q <= lo_q;
      out_ro_q <= ro_q;
    end
  end

  // checks
  a_accept_reads_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (fsm_q == ST_RDL))
    else $error("accepted word did not start the left tap read");

  a_wp_moves_on_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != ST_WR) |=> $stable(wp_q))
    else $error("write position moved outside the write-back cycle");

  a_mul_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fsm_q == ST_MUL) && (cnt_q == CNT_LAST)) |=> (fsm_q == ST_SUM))
    else $error("multiply pass did not end after the sign bit");

  a_no_idle_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_MIX) |-> ((fsm_q != ST_IDLE) && (fsm_q != ST_CLEAR)))
    else $error("multiply pass left open while idle");

  a_fin_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fsm_q == ST_FIN) && out_valid_q && !m_axis_tready) |=> (fsm_q == ST_FIN))
    else $error("finished word overran an untaken output word");

endmodule

@@ bench/stereo_feedback_delay_tone_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_tone_tb: self-checking bench for the stereo echo
// A directed table then phases of random stereo words under changing gain,
// tone and tap settings. Every output word is checked against the table's word
// or a bit-true model of the delay memory, tone filter and saturating mixers.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_tone_tb;
  import fdt_pkg::*;

  localparam int unsigned ECHO_DEPTH = DELAY_DEPTH_DEF;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_WORDS = 145;
  localparam int unsigned TAIL_CYCLES = 140;
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

  // indexes outside the register map, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 8'hFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } echo_pair_t;

  typedef enum logic {ROW_CFG, ROW_PAIR} row_kind_e;
  typedef enum logic [1:0] {SET_MUSICAL, SET_HIGH, SET_LOW, SET_RAW} setting_e;

  typedef struct {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      val;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    bit                         known;
    echo_pair_t                 want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*SAMPLE_W-1:0] s_axis_tdata;   // left_in [23:0], right_in [47:24]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [2*SAMPLE_W-1:0] m_axis_tdata;   // left_out [23:0], right_out [47:24]
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  stereo_feedback_delay_tone dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the block: delay memory, write pointer, tone state, registers
  logic signed [SAMPLE_W-1:0] echo_mem [ECHO_DEPTH];
  int unsigned                wr_pos;
  longint                     tone_state;
  logic [GAIN_W-1:0]          wet_q, dry_q, dmix_q;
  logic [FB_W-1:0]            fb_q;
  logic [COEFF_W-1:0]         coeff_q;
  logic signed [MIX_W-1:0]    lmix_q;
  logic [DIST_W-1:0]          ldist_q, rdist_q;

  echo_pair_t  pending_pairs [$];
  echo_pair_t  want_pair;
  stim_row_t   stim_rows [$];
  int unsigned mismatches;
  bit          quiet;

  // Round half up, floor shift
  function automatic longint rnd(input longint x, input int unsigned sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat(input longint v, input int unsigned bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Tap address, distance clamped to 4 .. depth
  function automatic int unsigned tap_pos(input int unsigned pos,
                                          input logic [DIST_W-1:0] span);
    int unsigned d, i;
    d = span;
    if (d < MIN_DELAY) d = MIN_DELAY;
    if (d > ECHO_DEPTH) d = ECHO_DEPTH;
    i = pos + d;
    if (i >= ECHO_DEPTH) i -= ECHO_DEPTH;
    return i;
  endfunction

  // One stereo word through the echo: taps, feedback sum, tone filter, write-back
  task automatic predict_echo(input logic signed [SAMPLE_W-1:0] l_in, r_in,
                              output echo_pair_t res);
    longint a, b, dl, dr, acc, tmp, t31, f0, word;
    int unsigned li, ri;
    a = l_in;
    b = r_in;
    li = tap_pos(wr_pos, ldist_q);
    ri = tap_pos(wr_pos, rdist_q);
    dl = echo_mem[li];
    dr = echo_mem[ri];
    acc = longint'(wet_q) * (a + b) + longint'(fb_q) * (dl + dr);
    tmp = sat(rnd(acc, 16), SAMPLE_W);
    t31 = tmp * 256;
    f0 = sat(rnd(longint'(coeff_q) * (tone_state - t31), 16) + t31, STATE_W);
    tone_state = f0;
    word = longint'(lmix_q) * f0 + longint'(dmix_q) * t31;
    echo_mem[wr_pos] = SAMPLE_W'(sat(rnd(word, 24), SAMPLE_W));
    wr_pos = (wr_pos == 0) ? ECHO_DEPTH - 1 : wr_pos - 1;
    res.left  = SAMPLE_W'(sat(rnd(longint'(dry_q) * a + dl * 65536, 16), SAMPLE_W));
    res.right = SAMPLE_W'(sat(rnd(longint'(dry_q) * b + dr * 65536, 16), SAMPLE_W));
  endtask

  // Register write; valid is left high, the next driver lowers it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_WET_GAIN:      wet_q   = val[GAIN_W-1:0];
      REG_DRY_GAIN:      dry_q   = val[GAIN_W-1:0];
      REG_FEEDBACK_GAIN: fb_q    = val[FB_W-1:0];
      REG_FILTER_COEFF:  coeff_q = val[COEFF_W-1:0];
      REG_LOWPASS_MIX:   lmix_q  = val[MIX_W-1:0];
      REG_DIRECT_MIX:    dmix_q  = val[GAIN_W-1:0];
      REG_LEFT_DELAY:    ldist_q = val[DIST_W-1:0];
      REG_RIGHT_DELAY:   rdist_q = val[DIST_W-1:0];
      default: ;
    endcase
  endtask

  // Stop sending and wait for every outstanding output word
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Send one stereo word, optionally after a random gap
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l, r,
                           input bit known, input echo_pair_t want);
    echo_pair_t pred;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_echo(l, r, pred);
    pending_pairs.push_back(known ? want : pred);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2, 3: begin
        v = int'($urandom_range(0, 2000)) - 1000;
        return SAMPLE_W'(v);
      end
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Mostly short taps so the feedback path sees fresh words
  function automatic logic [CFG_DATA_W-1:0] pick_dist();
    if ($urandom_range(0, 3) != 0) return $urandom_range(4, 300);
    return $urandom_range(0, 65535);
  endfunction

  task automatic program_phase(input setting_e mode);
    int lmix;
    case (mode)
      SET_HIGH: begin
        cfg_write(REG_WET_GAIN, 32'd131071);
        cfg_write(REG_DRY_GAIN, 32'd131071);
        cfg_write(REG_FEEDBACK_GAIN, 32'd32440);
        cfg_write(REG_FILTER_COEFF, 32'd65535);
        cfg_write(REG_LOWPASS_MIX, 32'd65536);
        cfg_write(REG_DIRECT_MIX, 32'd65536);
        cfg_write(REG_LEFT_DELAY, 32'd32768);
        cfg_write(REG_RIGHT_DELAY, 32'd65535);
      end
      SET_LOW: begin
        cfg_write(REG_WET_GAIN, 32'd0);
        cfg_write(REG_DRY_GAIN, 32'd0);
        cfg_write(REG_FEEDBACK_GAIN, 32'd0);
        cfg_write(REG_FILTER_COEFF, 32'd0);
        cfg_write(REG_LOWPASS_MIX, 32'hFFFF_8000);
        cfg_write(REG_DIRECT_MIX, 32'd0);
        cfg_write(REG_LEFT_DELAY, 32'd0);
        cfg_write(REG_RIGHT_DELAY, 32'd4);
      end
      SET_RAW: begin
        cfg_write(REG_WET_GAIN, $urandom());
        cfg_write(REG_DRY_GAIN, $urandom());
        cfg_write(REG_FEEDBACK_GAIN, $urandom());
        cfg_write(REG_FILTER_COEFF, $urandom());
        cfg_write(REG_LOWPASS_MIX, $urandom());
        cfg_write(REG_DIRECT_MIX, $urandom());
        cfg_write(REG_LEFT_DELAY, $urandom());
        cfg_write(REG_RIGHT_DELAY, $urandom());
      end
      default: begin
        lmix = int'($urandom_range(0, 98304)) - 32768;
        cfg_write(REG_WET_GAIN, $urandom_range(0, 131071));
        cfg_write(REG_DRY_GAIN, $urandom_range(0, 131071));
        cfg_write(REG_FEEDBACK_GAIN, $urandom_range(0, 32440));
        cfg_write(REG_FILTER_COEFF, $urandom_range(0, 65535));
        cfg_write(REG_LOWPASS_MIX, CFG_DATA_W'(lmix));
        cfg_write(REG_DIRECT_MIX, $urandom_range(0, 65536));
        cfg_write(REG_LEFT_DELAY, pick_dist());
        cfg_write(REG_RIGHT_DELAY, pick_dist());
      end
    endcase
    cfg_write(CFG_IDX_W'($urandom_range(REG_NONE_LO, REG_NONE_HI)), $urandom());
  endtask

  // Directed table builders
  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, val: val, l: '0, r: '0, known: 1'b0, want: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void row_pair(input logic signed [SAMPLE_W-1:0] l, r);
    stim_row_t row;
    row = '{kind: ROW_PAIR, idx: '0, val: '0, l: l, r: r, known: 1'b0, want: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void row_known(input logic signed [SAMPLE_W-1:0] l, r, el, er);
    stim_row_t row;
    echo_pair_t w;
    w.left  = el;
    w.right = er;
    row = '{kind: ROW_PAIR, idx: '0, val: '0, l: l, r: r, known: 1'b1, want: w};
    stim_rows.push_back(row);
  endfunction

  // Output check against the oldest expected word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("output word %h with none expected", m_axis_tdata);
      end else begin
        want_pair = pending_pairs.pop_front();
        if (m_axis_tdata[SAMPLE_W-1:0] !== want_pair.left ||
            m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want_pair.right) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                     want_pair.left, $signed(m_axis_tdata[SAMPLE_W-1:0]),
                     want_pair.right, $signed(m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]));
        end
      end
    end
  end

  // Receiver: random stall bursts, none in the last phase
  initial begin : sink_side
    int unsigned run;
    @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 18);
      if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
      end
      repeat (run) @(posedge clk_i);
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned ph, n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    quiet         = 1'b0;
    for (int i = 0; i < ECHO_DEPTH; i++) echo_mem[i] = '0;
    wr_pos     = 0;
    tone_state = 0;
    wet_q   = RST_WET_GAIN;
    dry_q   = RST_DRY_GAIN;
    fb_q    = RST_FEEDBACK_GAIN;
    coeff_q = RST_FILTER_COEFF;
    lmix_q  = RST_LOWPASS_MIX;
    dmix_q  = RST_DIRECT_MIX;
    ldist_q = RST_LEFT_DELAY;
    rdist_q = RST_RIGHT_DELAY;

    // Empty memory and unity dry gain: output equals input
    row_cfg(REG_DRY_GAIN, 32'h0001_0000);
    row_known(24'sd0, 24'sd0, 24'sd0, 24'sd0);
    row_known(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    row_known(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    row_known(24'sd1, -24'sd1, 24'sd1, -24'sd1);
    // Largest dry gain saturates both ways
    row_cfg(REG_DRY_GAIN, 32'd131071);
    row_known(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
    // No dry path, taps still empty
    row_cfg(REG_DRY_GAIN, 32'd0);
    row_known(24'sh123456, -24'sd5, 24'sd0, 24'sd0);
    // Hot feedback, short tap clamped up, long tap clamped to the oldest word
    row_cfg(REG_DRY_GAIN, 32'd58399);
    row_cfg(REG_WET_GAIN, 32'd131071);
    row_cfg(REG_FEEDBACK_GAIN, 32'd32767);
    row_cfg(REG_FILTER_COEFF, 32'd65535);
    row_cfg(REG_LOWPASS_MIX, 32'hFFFF_8000);
    row_cfg(REG_DIRECT_MIX, 32'd0);
    row_cfg(REG_LEFT_DELAY, 32'd0);
    row_cfg(REG_RIGHT_DELAY, 32'd65535);
    row_pair(SMP_MAX, SMP_MAX);
    row_pair(SMP_MIN, SMP_MIN);
    row_pair(SMP_MAX, SMP_MIN);
    row_pair(24'sd0, 24'sd0);
    row_pair(24'sd77, -24'sd4096);
    row_pair(SMP_MIN, SMP_MAX);
    // Tap exactly at full depth, shortest tap, full lowpass weight
    row_cfg(REG_LEFT_DELAY, 32'd32768);
    row_cfg(REG_RIGHT_DELAY, 32'd4);
    row_cfg(REG_LOWPASS_MIX, 32'd65536);
    row_cfg(REG_DIRECT_MIX, 32'd65536);
    row_cfg(REG_FILTER_COEFF, 32'd0);
    row_cfg(REG_FEEDBACK_GAIN, 32'd32440);
    row_cfg(REG_NONE_LO, 32'hFFFF_FFFF);
    row_cfg(REG_NONE_HI, 32'hFFFF_FFFF);
    row_pair(SMP_MAX, SMP_MAX);
    row_pair(24'sh400000, -24'sh400000);
    row_pair(SMP_MIN, 24'sd0);
    row_pair(24'sd0, SMP_MAX);
    row_pair(-24'sd1, -24'sd1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain();
        cfg_write(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_pair(stim_rows[i].l, stim_rows[i].r, stim_rows[i].known, stim_rows[i].want);
      end
    end

    // Random phases; each starts from a drained pipe
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == PHASES - 1) quiet = 1'b1;
      case (ph % 5)
        1: program_phase(SET_HIGH);
        3: program_phase(SET_RAW);
        4: program_phase(SET_LOW);
        default: program_phase(SET_MUSICAL);
      endcase
      for (n = 0; n < PHASE_WORDS; n++) send_pair(rand_sample(), rand_sample(), 1'b0, '0);
    end

    drain();
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
